[rtl/fcf_pkg.sv]
// Shared types and constants for the field comb factor block.
// No dependencies; every other file in rtl imports this package.
package fcf_pkg;

   localparam int LumaWidth       = 8;
   localparam int EnergyWidth     = 29;
   localparam int TotalWidth      = 23;
   localparam int RootWidth       = (EnergyWidth + 1) / 2;
   localparam int RemWidth        = RootWidth + 2;
   localparam int RadWidth        = 2 * RootWidth;
   localparam int StepCountWidth  = $clog2(RootWidth);
   localparam int SquareWidth     = 2 * (LumaWidth + 1);

   localparam logic [EnergyWidth-1:0] LineEnergyMax = {EnergyWidth{1'b1}};
   localparam logic [TotalWidth-1:0]  FieldTotalMax = TotalWidth'(8355840);
   localparam logic [StepCountWidth-1:0] LastRootStep = StepCountWidth'(RootWidth - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DONE
   } fcf_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // item taken this cycle
      logic load_root;  // item closes a line: start the root
      logic root_step;  // one root digit
      logic finish;     // add root into the field total
   } fcf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_close;  // pending item has line_end or field_end
      logic field_flag;  // root in flight belongs to a field end
      logic out_valid;   // result register full
   } fcf_status_type;

endpackage

[rtl/fcf_if.sv]
// Valid/ready channel interfaces for pixel items and comb factor results.
// Depends on fcf_pkg for field widths.
interface fcf_req_if;
   import fcf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [LumaWidth-1:0] luma_above;
   logic [LumaWidth-1:0] luma_middle;
   logic [LumaWidth-1:0] luma_below;
   logic                 line_end;
   logic                 field_end;

   modport source (
      output valid, luma_above, luma_middle, luma_below, line_end, field_end,
      input  ready
   );
   modport sink (
      input  valid, luma_above, luma_middle, luma_below, line_end, field_end,
      output ready
   );
endinterface

interface fcf_rsp_if;
   import fcf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TotalWidth-1:0] comb_factor;

   modport source (output valid, comb_factor, input ready);
   modport sink   (input valid, comb_factor, output ready);
endinterface

[rtl/fcf_ctrl.sv]
// Controller: input handshake and sequencing of the digit-serial square root.
// Depends on fcf_pkg (state enum, command and status structs).
module fcf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   input  fcf_pkg::fcf_status_type status,
   output fcf_pkg::fcf_cmd_type    cmd
);
   import fcf_pkg::*;

   fcf_state_type             state_ff, state_in;
   logic [StepCountWidth-1:0] step_ff, step_in;
   logic                      can_finish;
   logic                      last_step;

   assign last_step  = (step_ff == LastRootStep);
   // a field-closing root may only finish when the result register frees up
   assign can_finish = !status.field_flag || !status.out_valid || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_root) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (can_finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      // plain pixels keep flowing while a root is in flight
      req_ready      = (state_ff == ST_IDLE) || !status.item_close;
      cmd.accept     = req_valid && req_ready;
      cmd.load_root  = cmd.accept && status.item_close;
      cmd.root_step  = (state_ff == ST_ROOT);
      cmd.finish     = (state_ff == ST_DONE) && can_finish;
      step_in        = step_ff;
      case (state_ff)
         ST_ROOT: step_in = step_ff + StepCountWidth'(1);
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_no_close_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !(cmd.accept && status.item_close))
      else $error("line-closing item taken while a root is in flight");

   a_done_after_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ($past(state_ff) == ST_ROOT || $past(state_ff) == ST_DONE))
      else $error("finish state entered without a root");

   a_root_full_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && !last_step) |=> (state_ff == ST_ROOT))
      else $error("root left before its last digit");

endmodule

[rtl/fcf_dp.sv]
// Datapath: pixel deviation square, line energy, square root digits,
// field total and the result register. Depends on fcf_pkg.
module fcf_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  fcf_pkg::fcf_cmd_type        cmd,
   output fcf_pkg::fcf_status_type     status,
   input  logic [fcf_pkg::LumaWidth-1:0] luma_above,
   input  logic [fcf_pkg::LumaWidth-1:0] luma_middle,
   input  logic [fcf_pkg::LumaWidth-1:0] luma_below,
   input  logic                        line_end,
   input  logic                        field_end,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [fcf_pkg::TotalWidth-1:0] comb_factor
);
   import fcf_pkg::*;

   localparam int DevWidth = LumaWidth + 3;

   logic [EnergyWidth-1:0] energy_ff, energy_in;
   logic [RadWidth-1:0]    rad_ff, rad_in;
   logic [RemWidth-1:0]    rem_ff, rem_in;
   logic [RootWidth-1:0]   root_ff, root_in;
   logic                   field_flag_ff, field_flag_in;
   logic [TotalWidth-1:0]  total_ff, total_in;
   logic                   out_valid_ff, out_valid_in;
   logic [TotalWidth-1:0]  comb_ff, comb_in;

   logic signed [DevWidth-1:0] dev;
   logic [LumaWidth:0]         dev_abs;
   logic [SquareWidth-1:0]     square;
   logic [EnergyWidth:0]       energy_sum;
   logic [EnergyWidth-1:0]     energy_sat;
   logic [RemWidth+1:0]        rem_shift;
   logic [RemWidth+1:0]        trial;
   logic [TotalWidth:0]        total_sum;
   logic [TotalWidth-1:0]      total_sat;

   always_comb begin
      dev = signed'(DevWidth'(luma_above)) + signed'(DevWidth'(luma_below))
            - signed'(DevWidth'({luma_middle, 1'b0}));
      dev_abs    = dev[DevWidth-1] ? (LumaWidth+1)'(-dev) : (LumaWidth+1)'(dev);
      square     = dev_abs * dev_abs;
      energy_sum = (EnergyWidth+1)'(energy_ff) + (EnergyWidth+1)'(square);
      energy_sat = energy_sum[EnergyWidth] ? LineEnergyMax : energy_sum[EnergyWidth-1:0];

      // one root digit: bring down two radicand bits, try 4q+1
      rem_shift = {rem_ff, rad_ff[RadWidth-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};

      total_sum = (TotalWidth+1)'(total_ff) + (TotalWidth+1)'(root_ff);
      total_sat = (total_sum > (TotalWidth+1)'(FieldTotalMax)) ? FieldTotalMax
                                                               : total_sum[TotalWidth-1:0];
   end

   always_comb begin
      energy_in     = energy_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      field_flag_in = field_flag_ff;
      total_in      = total_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      comb_in       = comb_ff;

      if (cmd.accept) begin
         energy_in = cmd.load_root ? '0 : energy_sat;
      end
      if (cmd.load_root) begin
         rad_in        = RadWidth'(energy_sat);
         rem_in        = '0;
         root_in       = '0;
         field_flag_in = field_end;
      end else if (cmd.root_step) begin
         rad_in = {rad_ff[RadWidth-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = RemWidth'(rem_shift - trial);
            root_in = {root_ff[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = RemWidth'(rem_shift);
            root_in = {root_ff[RootWidth-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         if (field_flag_ff) begin
            total_in     = '0;
            comb_in      = total_sat;
            out_valid_in = 1'b1;
         end else begin
            total_in = total_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff     <= '0;
         total_ff      <= '0;
         out_valid_ff  <= 1'b0;
         field_flag_ff <= 1'b0;
      end else begin
         energy_ff     <= energy_in;
         total_ff      <= total_in;
         out_valid_ff  <= out_valid_in;
         field_flag_ff <= field_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      comb_ff <= comb_in;
   end

   assign status.item_close = line_end || field_end;
   assign status.field_flag = field_flag_ff;
   assign status.out_valid  = out_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign comb_factor       = comb_ff;

   a_energy_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.load_root |=> (energy_ff == '0))
      else $error("line energy not cleared after line close");

   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && field_flag_ff) |=> (total_ff == '0 && out_valid_ff))
      else $error("field total not cleared or result missing after field end");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      (total_ff <= FieldTotalMax) && (!out_valid_ff || comb_ff <= FieldTotalMax))
      else $error("field total above its saturation limit");

endmodule

[rtl/field_comb_factor.sv]
// Field comb factor: items that do not close a line are taken every cycle; a
// line-closing item starts a 15-digit square root (one digit per cycle), after which
// the root is added into the field total; a field end moves that total into the result
// register. The next line-closing item is not taken until the previous root has been
// added (later while a field total waits for an unread result).
// Synchronous active-high reset clears line energy, field total and the result valid.
module field_comb_factor (
   input  logic       clock,
   input  logic       reset,
   fcf_req_if.sink    req_chan,
   fcf_rsp_if.source  rsp_chan
);
   import fcf_pkg::*;

   fcf_cmd_type    cmd;
   fcf_status_type status;

   fcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .luma_above  (req_chan.luma_above),
      .luma_middle (req_chan.luma_middle),
      .luma_below  (req_chan.luma_below),
      .line_end    (req_chan.line_end),
      .field_end   (req_chan.field_end),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .comb_factor (rsp_chan.comb_factor)
   );

endmodule
